// ----- src/expg_pkg.sv -----
// Shared types, command codes and constants of the Exp-Golomb bit writer.
package expg_pkg;

    localparam logic [2:0] CMD_FIX_ESC = 3'd0;
    localparam logic [2:0] CMD_FIX_RAW = 3'd1;
    localparam logic [2:0] CMD_UE      = 3'd2;
    localparam logic [2:0] CMD_SE      = 3'd3;
    localparam logic [2:0] CMD_FLUSH   = 3'd4;

    localparam int unsigned CODE_BITS      = 33;
    localparam int unsigned GOLOMB_W       = 17;
    localparam int unsigned FIXED_MAX_BITS = 32;
    localparam logic [16:0] UE_MAX_CODE    = 17'd131070;
    localparam logic [7:0]  PREVENT_BYTE   = 8'h03;
    localparam int unsigned QUEUE_DEPTH    = 2;

    // One job for the back end: code bits left-aligned in a 33-bit word
    typedef struct packed {
        logic [CODE_BITS-1:0] bits;
        logic [5:0]           count;
        logic                 esc;
        logic                 flush;
    } t_job;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_q_stat;

endpackage

// ----- src/expg_if.sv -----
// Request channel interfaces of the Exp-Golomb bit writer.
interface expg_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [31:0]        uvalue;
    logic signed [16:0] svalue;
    logic [5:0]         bit_count;

    modport source (output valid, cmd, uvalue, svalue, bit_count, input ready);
    modport sink   (input valid, cmd, uvalue, svalue, bit_count, output ready);
endinterface

interface expg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// ----- src/expg_front.sv -----
// Front end: accept requests, map them to left-aligned code jobs.
module expg_front (
    expg_in_if.sink          i_in,
    input  expg_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output expg_pkg::t_job   o_job
);
    import expg_pkg::*;

    logic [5:0]          cnt_sat;
    logic [16:0]         mag;
    logic [17:0]         mapped;
    logic [16:0]         code;
    logic [16:0]         code_p1;
    logic [4:0]          glen;
    logic [5:0]          gcount;
    logic [CODE_BITS-1:0] raw;
    logic [5:0]          count;
    logic                keep;

    always_comb begin
        cnt_sat = (i_in.bit_count > 6'(FIXED_MAX_BITS)) ? 6'(FIXED_MAX_BITS) : i_in.bit_count;

        // signed map: v > 0 to 2v-1, v <= 0 to -2v
        mag = i_in.svalue[16] ? (~i_in.svalue + 17'd1) : i_in.svalue;
        if (i_in.svalue[16] || (mag == 17'd0)) begin
            mapped = {mag, 1'b0};
        end else begin
            mapped = {mag, 1'b0} - 18'd1;
        end

        if (i_in.cmd == CMD_UE) begin
            code = (i_in.uvalue > 32'(UE_MAX_CODE)) ? UE_MAX_CODE : i_in.uvalue[16:0];
        end else begin
            code = (mapped > 18'(UE_MAX_CODE)) ? UE_MAX_CODE : mapped[16:0];
        end
        code_p1 = code + 17'd1;

        glen = 5'd0;
        for (int i = 0; i < GOLOMB_W; i++) begin
            if (code_p1[i]) begin
                glen = 5'(i + 1);
            end
        end
        gcount = {glen, 1'b0} - 6'd1;

        keep  = 1'b0;
        raw   = '0;
        count = 6'd0;
        o_job.esc   = 1'b1;
        o_job.flush = 1'b0;
        case (i_in.cmd)
            CMD_FIX_ESC, CMD_FIX_RAW: begin
                raw       = {1'b0, i_in.uvalue};
                count     = cnt_sat;
                keep      = (cnt_sat != 6'd0);
                o_job.esc = (i_in.cmd == CMD_FIX_ESC);
            end
            CMD_UE, CMD_SE: begin
                raw   = {16'd0, code_p1};
                count = gcount;
                keep  = 1'b1;
            end
            CMD_FLUSH: begin
                keep        = 1'b1;
                o_job.flush = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase

        o_job.count = count;
        o_job.bits  = raw << (6'(CODE_BITS) - count);
    end

    assign i_in.ready = i_q_stat.not_full;
    assign o_push     = i_in.valid && i_q_stat.not_full && keep;

endmodule

// ----- src/expg_queue.sv -----
// Short job queue between front and back end.
module expg_queue #(
    parameter int unsigned DEPTH = expg_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  expg_pkg::t_job     i_job,
    input  logic               i_pop,
    output expg_pkg::t_job     o_head,
    output expg_pkg::t_q_stat  o_stat
);
    import expg_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_stat.not_empty = (r_cnt != CW'(0));
    assign o_stat.not_full  = (r_cnt != CW'(DEPTH));
    assign do_push = i_push && o_stat.not_full;
    assign do_pop  = i_pop && o_stat.not_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? AW'(0) : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? AW'(0) : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- src/expg_back.sv -----
// Back end: pack job bits into bytes, apply emulation prevention, drive output.
module expg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  expg_pkg::t_q_stat i_q_stat,
    input  expg_pkg::t_job    i_head,
    output logic              o_pop,
    expg_out_if.source        o_out
);
    import expg_pkg::*;

    logic                 r_busy, n_busy;
    logic [CODE_BITS-1:0] r_bits, n_bits;
    logic [5:0]           r_rem, n_rem;
    logic                 r_esc, n_esc;
    logic                 r_flush, n_flush;
    logic [7:0]           r_partial, n_partial;
    logic [2:0]           r_fill, n_fill;
    logic [1:0]           r_zrun, n_zrun;
    logic                 r_pend, n_pend;
    logic [7:0]           r_pend_byte, n_pend_byte;
    logic                 r_pend_last, n_pend_last;
    logic                 r_ov, n_ov;
    logic [7:0]           r_ob, n_ob;
    logic                 r_ol, n_ol;

    logic       free;
    logic [3:0] room;
    logic [3:0] take;
    logic [3:0] fill_sum;
    logic [7:0] merged;
    logic [5:0] rem_n;
    logic [7:0] fin_byte;
    logic       fin_last;
    logic       fin_do;
    logic       insert;

    assign free  = !r_ov || o_out.ready;
    assign o_pop = !r_busy && i_q_stat.not_empty;

    always_comb begin
        room     = 4'd8 - {1'b0, r_fill};
        take     = (r_rem < {2'b00, room}) ? r_rem[3:0] : room;
        fill_sum = {1'b0, r_fill} + take;
        merged   = r_partial | (r_bits[CODE_BITS-1 -: 8] >> r_fill);
        rem_n    = r_rem - {2'b00, take};

        n_busy      = r_busy;
        n_bits      = r_bits;
        n_rem       = r_rem;
        n_esc       = r_esc;
        n_flush     = r_flush;
        n_partial   = r_partial;
        n_fill      = r_fill;
        n_zrun      = r_zrun;
        n_pend      = r_pend;
        n_pend_byte = r_pend_byte;
        n_pend_last = r_pend_last;
        n_ov        = r_ov && !o_out.ready;
        n_ob        = r_ob;
        n_ol        = r_ol;

        fin_do   = 1'b0;
        fin_byte = merged;
        fin_last = (rem_n < 6'd8);

        if (o_pop) begin
            n_busy  = 1'b1;
            n_bits  = i_head.bits;
            n_rem   = i_head.count;
            n_esc   = i_head.esc;
            n_flush = i_head.flush;
        end else if (r_busy && free) begin
            if (r_pend) begin
                // release the data byte held behind an inserted 0x03
                n_ov   = 1'b1;
                n_ob   = r_pend_byte;
                n_ol   = r_pend_last;
                n_pend = 1'b0;
                n_busy = (r_rem != 6'd0);
            end else if (r_flush) begin
                n_busy = 1'b0;
                if (r_fill != 3'd0) begin
                    fin_do    = 1'b1;
                    fin_byte  = r_partial;
                    fin_last  = 1'b1;
                    n_partial = 8'd0;
                    n_fill    = 3'd0;
                end
            end else begin
                n_bits = r_bits << take;
                n_rem  = rem_n;
                n_busy = (rem_n != 6'd0);
                if (fill_sum[3]) begin
                    fin_do    = 1'b1;
                    n_partial = 8'd0;
                    n_fill    = 3'd0;
                end else begin
                    n_partial = merged;
                    n_fill    = fill_sum[2:0];
                end
            end
        end

        insert = r_esc && (r_zrun == 2'd2) && (fin_byte <= 8'd3);
        if (fin_do) begin
            n_ov = 1'b1;
            if (insert) begin
                n_ob        = PREVENT_BYTE;
                n_ol        = 1'b0;
                n_pend      = 1'b1;
                n_pend_byte = fin_byte;
                n_pend_last = fin_last;
                n_zrun      = 2'd0;
                n_busy      = 1'b1;
            end else begin
                n_ob = fin_byte;
                n_ol = fin_last;
                if (r_esc) begin
                    n_zrun = (fin_byte == 8'd0) ? r_zrun + 2'd1 : 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pend    <= 1'b0;
            r_ov      <= 1'b0;
            r_partial <= 8'd0;
            r_fill    <= 3'd0;
            r_zrun    <= 2'd0;
        end else begin
            r_busy    <= n_busy;
            r_pend    <= n_pend;
            r_ov      <= n_ov;
            r_partial <= n_partial;
            r_fill    <= n_fill;
            r_zrun    <= n_zrun;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits      <= n_bits;
        r_rem       <= n_rem;
        r_esc       <= n_esc;
        r_flush     <= n_flush;
        r_pend_byte <= n_pend_byte;
        r_pend_last <= n_pend_last;
        r_ob        <= n_ob;
        r_ol        <= n_ol;
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last     = r_ol;

endmodule

// ----- src/exp_golomb_bit_writer_epb.sv -----
// Top level of the Exp-Golomb bit writer with emulation prevention.
// Each input request is one command: a fixed field of 1 to 32 bits (escaped
// or unescaped), an unsigned or signed Exp-Golomb code (code number clamped
// to 131070), or a flush that sends out the open byte zero-padded. Bits are
// packed MSB first; every completed byte leaves as one output request, with
// last set on the final byte that the command produced. On escaped fields,
// Exp-Golomb codes and flush, a byte of 0x00 to 0x03 after two zero bytes is
// preceded by an inserted 0x03, and the zero count restarts after each
// insertion. The front end classifies a request in the cycle it is accepted
// and queues a job; the back end loads a job, then packs it in chunks of up
// to eight bits, with a step of its own for each inserted 0x03. A 33-bit code
// always spans five chunks. Undefined commands and zero-length fields are
// dropped in the front end and never reach the back end. The byte packer in
// the back end emits at most one byte per cycle into its output register and
// holds while the output is stalled; the queue lets requests arrive while
// earlier ones are still being packed.
module exp_golomb_bit_writer_epb #(
    parameter int unsigned P_QUEUE_DEPTH = expg_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    expg_in_if.sink    i_in,
    expg_out_if.source o_out
);
    import expg_pkg::*;

    // Front end to queue
    logic    push;
    t_job    push_job;
    // Queue to back end
    logic    pop;
    t_job    head_job;
    t_q_stat q_stat;

    // Classify the request and build a left-aligned job
    expg_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Hold jobs so that the front end keeps accepting while bytes drain
    expg_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // Pack bytes, insert prevention bytes, drive the output register
    expg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head_job),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// ----- src/expg_checker.sv -----
// Port-level checker of the Exp-Golomb bit writer and its bind.
module expg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // Hold a stalled output request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    // Drop any pending output on reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

    // Queue is empty after reset, so the input side must be ready
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready straight after reset");

endmodule

bind exp_golomb_bit_writer_epb expg_checker u_expg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the Exp-Golomb bit writer with emulation prevention.
`timescale 1ns / 1ps

module tb;
    import expg_pkg::*;

    // Command codes that the block does not define; it must ignore them
    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam int unsigned IDLE_PCT     = 14;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT  = 100000;

    logic i_clk;
    logic i_rst_n;

    expg_in_if  in_if();
    expg_out_if out_if();

    exp_golomb_bit_writer_epb u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Model state of the packer: open byte, its bit count and the zero-byte run
    logic [7:0] open_byte  = 8'h00;
    logic [2:0] open_bits  = 3'd0;
    logic [1:0] zero_run   = 2'd0;

    // Bytes still to come from the block, oldest first, with their last flags
    logic [7:0] expected_bytes[$];
    logic       expected_lasts[$];

    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    bit          burst_mode  = 1'b0;   // set: neither side idles

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[exp_golomb_bit_writer_epb] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Queue one completed byte. On escaped paths, insert the prevention
    // byte after two zero bytes when the byte is 0x00 to 0x03, and restart
    // the zero run after every insertion.
    function automatic void emit_byte(input logic [7:0] data, input bit esc);
        if (esc) begin
            if (zero_run == 2'd2 && data <= PREVENT_BYTE) begin
                expected_bytes.push_back(PREVENT_BYTE);
                expected_lasts.push_back(1'b0);
                zero_run = 2'd0;
            end else if (data == 8'h00) begin
                zero_run = zero_run + 2'd1;
            end else begin
                zero_run = 2'd0;
            end
        end
        expected_bytes.push_back(data);
        expected_lasts.push_back(1'b0);
    endfunction

    // Shift the low count bits of word into the open byte, MSB first
    function automatic void pack_bits(input logic [32:0] word, input int unsigned count,
                                      input bit esc);
        for (int i = int'(count) - 1; i >= 0; i--) begin
            open_byte[3'd7 - open_bits] = word[i];
            if (open_bits == 3'd7) begin
                emit_byte(open_byte, esc);
                open_byte = 8'h00;
                open_bits = 3'd0;
            end else begin
                open_bits = open_bits + 3'd1;
            end
        end
    endfunction

    // Exp-Golomb code of code_num: len-1 leading zeros, then code_num+1 in len bits
    function automatic void pack_golomb(input logic [31:0] code_num);
        logic [32:0] word;
        int unsigned len;
        if (code_num > UE_MAX_CODE)
            code_num = UE_MAX_CODE;
        word = {1'b0, code_num} + 33'd1;
        len  = 0;
        while (len < 32 && (word >> len) != 33'd0)
            len++;
        pack_bits(word, 2 * len - 1, 1'b1);
    endfunction

    // Work out every byte that one accepted command causes
    function automatic void pack_command(input logic [2:0] cmd, input logic [31:0] uvalue,
                                         input logic signed [16:0] svalue,
                                         input logic [5:0] bit_count);
        int unsigned first;
        int unsigned n_bits;
        int          sv;
        int          mapped;
        first  = expected_bytes.size();
        n_bits = (bit_count > FIXED_MAX_BITS) ? FIXED_MAX_BITS : bit_count;
        sv     = svalue;
        case (cmd)
            CMD_FIX_ESC, CMD_FIX_RAW: begin
                pack_bits({1'b0, uvalue}, n_bits, cmd == CMD_FIX_ESC);
            end
            CMD_UE: begin
                pack_golomb(uvalue);
            end
            CMD_SE: begin
                mapped = (sv > 0) ? 2 * sv - 1 : -2 * sv;
                pack_golomb(32'(mapped));
            end
            CMD_FLUSH: begin
                if (open_bits != 3'd0) begin
                    emit_byte(open_byte, 1'b1);
                    open_byte = 8'h00;
                    open_bits = 3'd0;
                end
            end
            default: begin
            end
        endcase
        if (expected_bytes.size() > first)
            expected_lasts[expected_lasts.size() - 1] = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request; hold it until accepted, then predict its bytes.
    // Valid is only ever lowered in a gap, so back-to-back requests keep it high.
    task automatic send_req(input logic [2:0] cmd, input logic [31:0] uvalue,
                            input logic signed [16:0] svalue, input logic [5:0] bit_count);
        if (!burst_mode) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid     <= 1'b1;
        in_if.cmd       <= cmd;
        in_if.uvalue    <= uvalue;
        in_if.svalue    <= svalue;
        in_if.bit_count <= bit_count;
        do @(posedge i_clk); while (!in_if.ready);
        pack_command(cmd, uvalue, svalue, bit_count);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order comparison
    // ------------------------------------------------------------------

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output byte %02h last %0b", out_if.out_byte,
                           out_if.last);
                    err_count++;
                end else begin
                    if (out_if.out_byte !== expected_bytes[0]) begin
                        $error("out_byte expected %02h actual %02h", expected_bytes[0],
                               out_if.out_byte);
                        err_count++;
                    end
                    if (out_if.last !== expected_lasts[0]) begin
                        $error("last expected %0b actual %0b", expected_lasts[0],
                               out_if.last);
                        err_count++;
                    end
                    void'(expected_bytes.pop_front());
                    void'(expected_lasts.pop_front());
                end
            end
            out_if.ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fixed fields at the width extremes, including zero and saturated counts
    task automatic test_fixed_fields();
        send_req(CMD_FIX_ESC, 32'h0000_0001, 17'sd0, 6'd1);
        send_req(CMD_FIX_RAW, 32'hFFFF_FFFF, 17'sd0, 6'd32);
        send_req(CMD_FIX_ESC, 32'hFFFF_FFFF, 17'sd0, 6'd0);
        send_req(CMD_FIX_ESC, 32'hA5C3_0F96, 17'sd0, 6'd33);
        send_req(CMD_FIX_RAW, 32'h5A3C_F069, 17'sd0, 6'd63);
        send_req(CMD_FIX_ESC, 32'h0000_0000, 17'sd0, 6'd7);
    endtask

    // Golomb codes: smallest, clamp edge, above the clamp, signed extremes
    task automatic test_golomb_codes();
        send_req(CMD_UE, 32'd0, 17'sd0, 6'd0);
        send_req(CMD_UE, 32'd131070, 17'sd0, 6'd0);
        send_req(CMD_UE, 32'd131071, 17'sd0, 6'd0);
        send_req(CMD_UE, 32'hFFFF_FFFF, 17'sd0, 6'd0);
        send_req(CMD_SE, 32'd0, 17'sd0, 6'd0);
        send_req(CMD_SE, 32'd0, 17'sd1, 6'd0);
        send_req(CMD_SE, 32'd0, -17'sd1, 6'd0);
        send_req(CMD_SE, 32'd0, 17'sd65535, 6'd0);
        send_req(CMD_SE, 32'd0, -17'sd65535, 6'd0);
        send_req(CMD_SE, 32'hFFFF_FFFF, 17'h10000, 6'd0);   // most negative value
    endtask

    // Prevention: insertion after two zero bytes, restart of the zero run,
    // unescaped bytes leaving the run alone, and a zero-padded flush
    task automatic test_prevention();
        send_req(CMD_FLUSH, 32'd0, 17'sd0, 6'd0);             // align to a byte
        send_req(CMD_FLUSH, 32'd0, 17'sd0, 6'd0);             // empty: no bytes
        send_req(CMD_FIX_ESC, 32'h0000_0000, 17'sd0, 6'd24);  // third zero gets 0x03
        send_req(CMD_FIX_ESC, 32'h0000_0001, 17'sd0, 6'd8);
        send_req(CMD_FIX_RAW, 32'h0000_0000, 17'sd0, 6'd16);  // run unchanged
        send_req(CMD_FIX_ESC, 32'h0000_0002, 17'sd0, 6'd8);
        send_req(CMD_FIX_ESC, 32'h0000_0000, 17'sd0, 6'd16);
        send_req(CMD_FIX_ESC, 32'h0000_0000, 17'sd0, 6'd3);
        send_req(CMD_FLUSH, 32'd0, 17'sd0, 6'd0);             // padded zero after run
    endtask

    // Undefined commands must cause nothing
    task automatic test_undefined_commands();
        send_req(CMD_RSVD_5, 32'hFFFF_FFFF, -17'sd1, 6'd32);
        send_req(CMD_RSVD_6, 32'h1234_5678, 17'sd100, 6'd8);
        send_req(CMD_RSVD_7, 32'h0000_0000, 17'sd0, 6'd63);
    endtask

    // One random command; zero-heavy fields so that the prevention path is
    // reached often, with a share of noise and out-of-range counts
    task automatic send_random_command();
        int unsigned pick;
        logic [31:0] uval;
        logic signed [16:0] sval;
        logic [5:0]  cnt;
        pick = $urandom_range(0, 99);
        uval = $urandom();
        sval = 17'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2:  cnt = 6'(8 * $urandom_range(1, 4));
            3:        cnt = 6'($urandom_range(0, 63));
            default:  cnt = 6'($urandom_range(1, 32));
        endcase
        if (pick < 12) begin
            // two zero bytes then a small byte: insertion expected when aligned
            send_req(CMD_FIX_ESC, 32'h0, sval, 6'd16);
            send_req(CMD_FIX_ESC, 32'($urandom_range(0, 3)), sval, 6'd8);
        end else if (pick < 35) begin
            case ($urandom_range(0, 4))
                0, 1: uval = 32'h0;
                2:    uval = 32'($urandom_range(0, 3));
                default: ;
            endcase
            send_req(CMD_FIX_ESC, uval, sval, cnt);
        end else if (pick < 47) begin
            if ($urandom_range(0, 1) == 0)
                uval = 32'h0;
            send_req(CMD_FIX_RAW, uval, sval, cnt);
        end else if (pick < 63) begin
            case ($urandom_range(0, 6))
                0, 1, 2, 3: uval = 32'($urandom_range(0, 300));
                4, 5:       uval = 32'($urandom_range(0, 131071));
                default: ;
            endcase
            send_req(CMD_UE, uval, sval, cnt);
        end else if (pick < 79) begin
            if ($urandom_range(0, 1) == 0)
                sval = 17'(int'($urandom_range(0, 20)) - 10);
            send_req(CMD_SE, uval, sval, cnt);
        end else if (pick < 93) begin
            send_req(CMD_FLUSH, uval, sval, cnt);
        end else begin
            send_req(3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7)), uval, sval,
                     6'($urandom_range(0, 63)));
        end
    endtask

    // Random stream with idling on both sides
    task automatic test_random_stream(input int unsigned n_items);
        for (int unsigned i = 0; i < n_items; i++)
            send_random_command();
    endtask

    // Random stream with neither side idling
    task automatic test_streaming_no_idle(input int unsigned n_items);
        burst_mode = 1'b1;
        for (int unsigned i = 0; i < n_items; i++)
            send_random_command();
        burst_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.cmd       <= CMD_FLUSH;
        in_if.uvalue    <= 32'h0;
        in_if.svalue    <= 17'sd0;
        in_if.bit_count <= 6'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fixed_fields();
        test_golomb_codes();
        test_prevention();
        test_undefined_commands();
        test_random_stream(45);
        test_streaming_no_idle(25);
        send_req(CMD_FLUSH, 32'h0, 17'sd0, 6'd0);   // drain the open byte
        in_if.valid <= 1'b0;

        // Wait for every predicted byte, then give stray output a chance to show
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("[exp_golomb_bit_writer_epb] OK");
        else
            $display("[exp_golomb_bit_writer_epb] ERROR");
        $finish;
    end

endmodule

// ----- exp_golomb_bit_writer_epb.f -----
src/expg_pkg.sv
src/expg_if.sv
src/expg_front.sv
src/expg_queue.sv
src/expg_back.sv
src/exp_golomb_bit_writer_epb.sv
src/expg_checker.sv
tb/tb.sv
